// ===== sv/pbv_pkg.sv =====
// ----------------------------------------------------------------------------
// pbv_pkg: shared types and constants for the packed bit vector
// Request and status codes, internal op codes, back-end states and the
// control group that travels from the classifier to the executor.
// ----------------------------------------------------------------------------
package pbv_pkg;

  localparam int CAPACITY_DEF = 256;  // default bit capacity
  localparam int WORD_BITS    = 8;    // bits per store word
  localparam int WORD_SHIFT   = 3;    // log2(WORD_BITS)
  localparam int REQ_W        = 3;
  localparam int POS_W        = 8;
  localparam int LEN_W        = 9;
  localparam int STAT_W       = 2;
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_READ   = 3'd1,
    REQ_WRITE  = 3'd2,
    REQ_INSERT = 3'd3,
    REQ_ERASE  = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // work left for the executor after classification
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_INSERT = 3'd3,
    OP_ERASE  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE   = 2'd0,
    B_READ   = 2'd1,
    B_MODIFY = 2'd2,
    B_RESULT = 2'd3
  } bstate_t;

  typedef struct packed {
    op_t     op;
    status_t status;
    logic    val;
  } cmd_ctl_t;

endpackage

// ===== sv/pbv_ifs.sv =====
// ----------------------------------------------------------------------------
// pbv_ifs: request and response channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface pbv_req_if;
  logic                      valid;
  logic                      ready;
  logic [pbv_pkg::REQ_W-1:0] req_type;
  logic [pbv_pkg::POS_W-1:0] position;
  logic                      bit_value;

  modport source (output valid, req_type, position, bit_value, input ready);
  modport sink   (input valid, req_type, position, bit_value, output ready);
endinterface

interface pbv_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       read_bit;
  logic [pbv_pkg::LEN_W-1:0]  length;
  logic [pbv_pkg::STAT_W-1:0] status;

  modport source (output valid, read_bit, length, status, input ready);
  modport sink   (input valid, read_bit, length, status, output ready);
endinterface

// ===== sv/pbv_front.sv =====
// ----------------------------------------------------------------------------
// pbv_front: request classifier
// Owns the bit count, range-checks each item, settles status and new length
// and turns the item into a word-level command for the executor.
// ----------------------------------------------------------------------------
module pbv_front #(
  parameter int CAPACITY = pbv_pkg::CAPACITY_DEF,
  localparam int NWORDS  = (CAPACITY + pbv_pkg::WORD_BITS - 1) / pbv_pkg::WORD_BITS,
  localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  pbv_req_if.sink                         req,
  output logic                            push_valid,
  input  logic                            push_ready,
  output pbv_pkg::cmd_ctl_t               ctl,
  output logic [pbv_pkg::WORD_SHIFT-1:0]  bit_sel,
  output logic [AW-1:0]                   word_a,
  output logic [AW-1:0]                   word_b,
  output logic [pbv_pkg::LEN_W-1:0]       len
);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int XW     = (CW > pbv_pkg::LEN_W) ? CW : pbv_pkg::LEN_W;

  logic [CW-1:0] cnt, cnt_next;
  logic [XW-1:0] cnt_x, pos_x, idx_x, wb_x, len_x;
  logic [XW-1:0] cap_x;

  assign req.ready  = push_ready;
  assign push_valid = req.valid;
  assign cap_x      = XW'(CAPACITY);

  always_comb begin
    cnt_x      = XW'(cnt);
    pos_x      = XW'(req.position);
    ctl.op     = pbv_pkg::OP_NONE;
    ctl.status = pbv_pkg::ST_OK;
    ctl.val    = req.bit_value;
    cnt_next   = cnt;
    idx_x      = pos_x;
    wb_x       = pos_x;
    unique case (pbv_pkg::req_t'(req.req_type))
      pbv_pkg::REQ_APPEND: begin
        if (cnt_x >= cap_x) begin
          ctl.status = pbv_pkg::ST_FULL;
        end else begin
          ctl.op   = pbv_pkg::OP_WRITE;
          idx_x    = cnt_x;
          wb_x     = cnt_x;
          cnt_next = cnt + CW'(1);
        end
      end
      pbv_pkg::REQ_READ: begin
        if (pos_x >= cnt_x) ctl.status = pbv_pkg::ST_RANGE;
        else ctl.op = pbv_pkg::OP_READ;
      end
      pbv_pkg::REQ_WRITE: begin
        if (pos_x >= cnt_x) ctl.status = pbv_pkg::ST_RANGE;
        else ctl.op = pbv_pkg::OP_WRITE;
      end
      pbv_pkg::REQ_INSERT: begin
        if (pos_x > cnt_x) begin
          ctl.status = pbv_pkg::ST_RANGE;
        end else if (cnt_x >= cap_x) begin
          ctl.status = pbv_pkg::ST_FULL;
        end else begin
          ctl.op   = pbv_pkg::OP_INSERT;
          wb_x     = cnt_x;           // word holding the new top bit
          cnt_next = cnt + CW'(1);
        end
      end
      pbv_pkg::REQ_ERASE: begin
        if (pos_x >= cnt_x) begin
          ctl.status = pbv_pkg::ST_RANGE;
        end else begin
          ctl.op   = pbv_pkg::OP_ERASE;
          wb_x     = cnt_x - XW'(1);  // word holding the current top bit
          cnt_next = cnt - CW'(1);
        end
      end
      default: begin
        // unused codes: reported as ok, nothing changes
      end
    endcase
    len_x   = XW'(cnt_next);
    len     = len_x[pbv_pkg::LEN_W-1:0];
    bit_sel = idx_x[pbv_pkg::WORD_SHIFT-1:0];
    word_a  = AW'(idx_x >> pbv_pkg::WORD_SHIFT);
    word_b  = AW'(wb_x >> pbv_pkg::WORD_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.valid && push_ready) begin
      cnt <= cnt_next;
    end
  end

endmodule

// ===== sv/pbv_queue.sv =====
// ----------------------------------------------------------------------------
// pbv_queue: command queue
// Small FIFO between classifier and executor.
// ----------------------------------------------------------------------------
module pbv_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  localparam int DEPTH = pbv_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(DEPTH + 1);

  logic [W-1:0]  entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [FW-1:0] fill;
  logic          push, pop;

  assign in_ready  = (fill != FW'(DEPTH));
  assign out_valid = (fill != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      fill <= fill + FW'(1);
      else if (pop && !push) fill <= fill - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_data;
  end

endmodule

// ===== sv/pbv_back.sv =====
// ----------------------------------------------------------------------------
// pbv_back: word executor
// Holds the bit store and walks it word by word with read-modify-write,
// carrying one bit between words for insert (upward) and erase (downward).
// ----------------------------------------------------------------------------
module pbv_back #(
  parameter int CAPACITY = pbv_pkg::CAPACITY_DEF,
  localparam int NWORDS  = (CAPACITY + pbv_pkg::WORD_BITS - 1) / pbv_pkg::WORD_BITS,
  localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  pbv_pkg::cmd_ctl_t               cmd_ctl,
  input  logic [pbv_pkg::WORD_SHIFT-1:0]  cmd_bit_sel,
  input  logic [AW-1:0]                   cmd_word_a,
  input  logic [AW-1:0]                   cmd_word_b,
  input  logic [pbv_pkg::LEN_W-1:0]       cmd_len,
  pbv_rsp_if.source                       rsp
);
  localparam int WB     = pbv_pkg::WORD_BITS;
  localparam int SW     = pbv_pkg::WORD_SHIFT;

  pbv_pkg::bstate_t  state, state_next;
  pbv_pkg::cmd_ctl_t c_ctl;
  logic [SW-1:0]     c_bit_sel;
  logic [AW-1:0]     c_word_a, c_word_b;
  logic [pbv_pkg::LEN_W-1:0] c_len;

  logic [AW-1:0] cur, stop;
  logic          carry, carry_new, rbit;
  logic          at_stop, mem_we, out_load;
  logic [WB-1:0] mem [NWORDS];
  logic [WB-1:0] rd_data, new_word, up_word, dn_word;
  logic [SW-1:0] b_eff, jj;

  logic                        out_valid, out_rbit;
  logic [pbv_pkg::LEN_W-1:0]   out_len;
  pbv_pkg::status_t            out_status;

  assign stop    = (c_ctl.op == pbv_pkg::OP_ERASE) ? c_word_a : c_word_b;
  assign at_stop = (cur == stop);
  assign b_eff   = (cur == c_word_a) ? c_bit_sel : '0;
  assign up_word = {rd_data[WB-2:0], 1'b0};
  assign dn_word = {1'b0, rd_data[WB-1:1]};

  // word update
  always_comb begin
    new_word  = rd_data;
    carry_new = carry;
    for (int j = 0; j < WB; j++) begin
      jj = SW'(j);
      unique case (c_ctl.op)
        pbv_pkg::OP_WRITE: begin
          if (jj == b_eff) new_word[j] = c_ctl.val;
        end
        pbv_pkg::OP_INSERT: begin
          if (jj == b_eff)     new_word[j] = carry;
          else if (jj > b_eff) new_word[j] = up_word[j];
        end
        pbv_pkg::OP_ERASE: begin
          if (jj == SW'(WB - 1)) new_word[j] = carry;
          else if (jj >= b_eff)  new_word[j] = dn_word[j];
        end
        default: begin
        end
      endcase
    end
    if (c_ctl.op == pbv_pkg::OP_INSERT)     carry_new = rd_data[WB-1];
    else if (c_ctl.op == pbv_pkg::OP_ERASE) carry_new = rd_data[b_eff];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pbv_pkg::B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      pbv_pkg::B_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_next = (cmd_ctl.op == pbv_pkg::OP_NONE) ? pbv_pkg::B_RESULT
                                                        : pbv_pkg::B_READ;
        end
      end
      pbv_pkg::B_READ: state_next = pbv_pkg::B_MODIFY;
      pbv_pkg::B_MODIFY: begin
        mem_we     = (c_ctl.op != pbv_pkg::OP_READ);
        state_next = at_stop ? pbv_pkg::B_RESULT : pbv_pkg::B_READ;
      end
      pbv_pkg::B_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = pbv_pkg::B_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      c_ctl     <= cmd_ctl;
      c_bit_sel <= cmd_bit_sel;
      c_word_a  <= cmd_word_a;
      c_word_b  <= cmd_word_b;
      c_len     <= cmd_len;
      cur       <= (cmd_ctl.op == pbv_pkg::OP_ERASE) ? cmd_word_b : cmd_word_a;
      carry     <= (cmd_ctl.op == pbv_pkg::OP_INSERT) ? cmd_ctl.val : 1'b0;
      rbit      <= 1'b0;
    end else if (state == pbv_pkg::B_MODIFY) begin
      carry <= carry_new;
      if (c_ctl.op == pbv_pkg::OP_READ) rbit <= rd_data[c_bit_sel];
      if (!at_stop) begin
        cur <= (c_ctl.op == pbv_pkg::OP_ERASE) ? cur - AW'(1) : cur + AW'(1);
      end
    end
    if (out_load) begin
      out_rbit   <= rbit;
      out_len    <= c_len;
      out_status <= c_ctl.status;
    end
  end

  // bit store
  always_ff @(posedge clk) begin
    if (mem_we) mem[cur] <= new_word;
    rd_data <= mem[cur];
  end

  always_ff @(posedge clk) begin
    if (rst)           out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (rsp.ready) out_valid <= 1'b0;
  end

  assign rsp.valid    = out_valid;
  assign rsp.read_bit = out_rbit;
  assign rsp.length   = out_len;
  assign rsp.status   = out_status;

endmodule

// ===== sv/packed_bit_vector.sv =====
// ----------------------------------------------------------------------------
// packed_bit_vector: ordered bit vector with insert and erase
// Keeps up to CAPACITY bits packed eight to a word; append, read, write,
// insert and erase, one result item per request item.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------
//  req     | in  | valid/ready | req_type[2:0] position[7:0] bit_value
//  rsp     | out | valid/ready | read_bit length[8:0] status[1:0]
//
//  Store walk: each word (8 bits) is read and then written back, on the
//  single store port; reads skip the write. Read, write and append touch one
//  word. Insert at position p with length n walks words p/8 up through n/8,
//  erase walks (n-1)/8 down to p/8. The executor takes its next item only
//  once the last result is loaded into the output register.
//  Rejected requests skip the store.
//  Reset: synchronous; clears the bit count, the queue and the output valid.
//  The store itself is not cleared: bits at or above the length are never read.
//  Stalls: the classifier keeps taking items while the queue has room, even
//  with a result waiting at the output register.
//
module packed_bit_vector #(
  parameter int CAPACITY = pbv_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pbv_req_if.sink    req,
  pbv_rsp_if.source  rsp
);
  localparam int NWORDS = (CAPACITY + pbv_pkg::WORD_BITS - 1) / pbv_pkg::WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int XW     = (CW > pbv_pkg::LEN_W) ? CW : pbv_pkg::LEN_W;
  localparam int CMD_W  = $bits(pbv_pkg::cmd_ctl_t) + pbv_pkg::WORD_SHIFT + 2 * AW
                          + pbv_pkg::LEN_W;

  // classifier -> queue
  logic                            f_valid, f_ready;
  pbv_pkg::cmd_ctl_t               f_ctl;
  logic [pbv_pkg::WORD_SHIFT-1:0]  f_bit_sel;
  logic [AW-1:0]                   f_word_a, f_word_b;
  logic [pbv_pkg::LEN_W-1:0]       f_len;

  // queue -> executor
  logic                            q_valid, q_ready;
  logic [CMD_W-1:0]                q_in_data, q_out_data;
  pbv_pkg::cmd_ctl_t               b_ctl;
  logic [pbv_pkg::WORD_SHIFT-1:0]  b_bit_sel;
  logic [AW-1:0]                   b_word_a, b_word_b;
  logic [pbv_pkg::LEN_W-1:0]       b_len;

  pbv_front #(.CAPACITY(CAPACITY)) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .ctl        (f_ctl),
    .bit_sel    (f_bit_sel),
    .word_a     (f_word_a),
    .word_b     (f_word_b),
    .len        (f_len)
  );

  assign q_in_data = {f_ctl, f_bit_sel, f_word_a, f_word_b, f_len};

  pbv_queue #(.W(CMD_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (q_in_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_out_data)
  );

  assign {b_ctl, b_bit_sel, b_word_a, b_word_b, b_len} = q_out_data;

  pbv_back #(.CAPACITY(CAPACITY)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd_ctl     (b_ctl),
    .cmd_bit_sel (b_bit_sel),
    .cmd_word_a  (b_word_a),
    .cmd_word_b  (b_word_b),
    .cmd_len     (b_len),
    .rsp         (rsp)
  );

  // a rejected request never reports a bit
  a_err_no_bit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != pbv_pkg::ST_OK) |-> !rsp.read_bit)
    else $error("error result carries a read bit");

  // reported length never passes the capacity
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (XW'(rsp.length) <= XW'(CAPACITY)))
    else $error("length above capacity");

  // queue only drains through the executor
  a_q_drain: assert property (@(posedge clk) disable iff (rst)
    $fell(q_valid) |-> $past(q_ready))
    else $error("queue emptied without a pop");

  // executor leaves idle after taking a command from the queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_ready && q_valid |=> !q_ready)
    else $error("executor stayed idle after taking a command");

endmodule

// ===== verif/packed_bit_vector_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_bit_vector_chk: result checker for the packed bit vector
// Watches both channels, keeps its own bit store and length, works out the
// result of every accepted request and compares each returned result with
// the oldest outstanding one.
// ----------------------------------------------------------------------------
module packed_bit_vector_chk #(
  parameter int CAPACITY = pbv_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  pbv_req_if   req,
  pbv_rsp_if   rsp,
  output int   mismatches,
  output int   pending,
  output int   results_seen,
  output int   range_rejects,
  output int   full_rejects,
  output int   peak_length
);

  typedef struct {
    logic                      read_bit;
    logic [pbv_pkg::LEN_W-1:0] length;
    pbv_pkg::status_t          status;
  } bit_result_t;

  logic        shadow_bits [CAPACITY];
  int          shadow_len;
  bit_result_t expected_results [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 20) begin
      $display("[%0t] result %0d: %s got %0d, want %0d", $realtime, results_seen, what,
               got, want);
    end
    mismatches++;
  endtask

  // Bits at and above the length are never visible, so stale slots are harmless.
  task automatic apply_bit_request(input logic [pbv_pkg::REQ_W-1:0] kind, input int pos,
                                   input logic val, output bit_result_t res);
    res.read_bit = 1'b0;
    res.status   = pbv_pkg::ST_OK;
    case (kind)
      pbv_pkg::REQ_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          res.status = pbv_pkg::ST_FULL;
        end else begin
          shadow_bits[shadow_len] = val;
          shadow_len++;
        end
      end
      pbv_pkg::REQ_READ: begin
        if (pos >= shadow_len) res.status = pbv_pkg::ST_RANGE;
        else res.read_bit = shadow_bits[pos];
      end
      pbv_pkg::REQ_WRITE: begin
        if (pos >= shadow_len) res.status = pbv_pkg::ST_RANGE;
        else shadow_bits[pos] = val;
      end
      pbv_pkg::REQ_INSERT: begin
        if (pos > shadow_len) begin
          res.status = pbv_pkg::ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          res.status = pbv_pkg::ST_FULL;
        end else begin
          for (int i = shadow_len; i > pos; i--) shadow_bits[i] = shadow_bits[i-1];
          shadow_bits[pos] = val;
          shadow_len++;
        end
      end
      pbv_pkg::REQ_ERASE: begin
        if (pos >= shadow_len) begin
          res.status = pbv_pkg::ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < shadow_len; i++) shadow_bits[i] = shadow_bits[i+1];
          shadow_len--;
        end
      end
      default: ;  // unused codes leave everything alone
    endcase
    res.length = shadow_len[pbv_pkg::LEN_W-1:0];
  endtask

  always @(posedge clk) begin
    bit_result_t res;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) shadow_bits[i] = 1'b0;
      shadow_len = 0;
      expected_results.delete();
      mismatches     = 0;
      pending       <= 0;
      results_seen  <= 0;
      range_rejects <= 0;
      full_rejects  <= 0;
      peak_length   <= 0;
    end else begin
      if (req.valid && req.ready) begin
        apply_bit_request(req.req_type, int'(req.position), req.bit_value, res);
        expected_results.insert(expected_results.size(), res);
        if (res.status == pbv_pkg::ST_RANGE) range_rejects <= range_rejects + 1;
        if (res.status == pbv_pkg::ST_FULL) full_rejects <= full_rejects + 1;
        if (shadow_len > peak_length) peak_length <= shadow_len;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item, pending count", 0, 0);
        end else begin
          res = expected_results.pop_front();
          if (rsp.read_bit !== res.read_bit)
            report_mismatch("read_bit", int'(rsp.read_bit), int'(res.read_bit));
          if (rsp.length !== res.length)
            report_mismatch("length", int'(rsp.length), int'(res.length));
          if (rsp.status !== res.status)
            report_mismatch("status", int'(rsp.status), int'(res.status));
        end
        results_seen <= results_seen + 1;
      end
      pending <= expected_results.size();
    end
  end

endmodule

// ===== verif/packed_bit_vector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_bit_vector_tb: top level testbench for the packed bit vector
// Drives a short directed sequence, then phases that grow the vector to
// full, mix all operations, and shrink it back to empty, with random gaps
// on both channels and long output stalls; the checker does the scoring.
// ----------------------------------------------------------------------------
module packed_bit_vector_tb;

  typedef logic [pbv_pkg::REQ_W-1:0] req_code_t;

  localparam int CAP          = pbv_pkg::CAPACITY_DEF;
  localparam int POS_MAX      = (1 << pbv_pkg::POS_W) - 1;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASE_CAP    = 700;   // safety bound on one phase
  localparam int MIX_ITEMS    = 120;
  localparam int HOLD_CYCLES  = 400;   // long receiver stall
  localparam int DRAIN_CYCLES = 100;   // > longest insert/erase walk
  localparam int CYCLE_LIMIT  = 1_000_000;

  // request codes the block ignores
  localparam req_code_t REQ_UNUSED_FIRST = 3'd5;
  localparam req_code_t REQ_UNUSED_LAST  = 3'd7;

  typedef enum {PH_GROW, PH_MIX, PH_SHRINK} phase_t;

  logic clk;
  logic rst;

  pbv_req_if req_ch ();
  pbv_rsp_if rsp_ch ();

  int mismatches, pending, results_seen, range_rejects, full_rejects, peak_length;
  int cycles;
  int items_sent;
  int fill_est;     // length the vector should have once sent items land
  bit calm;         // no random idle gaps on either side while set

  packed_bit_vector #(.CAPACITY(CAP)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  packed_bit_vector_chk #(.CAPACITY(CAP)) chk (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .results_seen  (results_seen),
    .range_rejects (range_rejects),
    .full_rejects  (full_rejects),
    .peak_length   (peak_length)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // watchdog: a hung handshake ends the run here
  initial begin
    cycles = 0;
    wait (cycles >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d items still outstanding", cycles, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99, 0);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Track the length as items go out, so random positions can aim in range.
  // Order is preserved, so this matches what the block will hold.
  function automatic void track_fill(input req_code_t kind, input int pos);
    case (kind)
      pbv_pkg::REQ_APPEND: if (fill_est < CAP) fill_est++;
      pbv_pkg::REQ_INSERT: if (pos <= fill_est && fill_est < CAP) fill_est++;
      pbv_pkg::REQ_ERASE:  if (pos < fill_est) fill_est--;
      default: ;
    endcase
  endfunction

  // one request item; valid stays up across back-to-back items
  task automatic send_item(input req_code_t kind, input int pos, input logic val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.position  <= pos[pbv_pkg::POS_W-1:0];
    req_ch.bit_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    track_fill(kind, pos);
    if (items_sent % 64 == 0) calm = ($urandom_range(3, 0) == 0);
  endtask

  // Random request shaped by phase. Grow favors append/insert, shrink favors
  // erase, mix spreads evenly; a slice of each is raw noise (any code,
  // any position), which also brings in the unused codes.
  task automatic send_random_item(input phase_t phase);
    int roll, pos;
    req_code_t kind;
    roll = $urandom_range(99, 0);
    if (phase == PH_GROW) begin
      kind = (roll < 45) ? pbv_pkg::REQ_APPEND :
             (roll < 80) ? pbv_pkg::REQ_INSERT : REQ_UNUSED_LAST;
    end else if (phase == PH_SHRINK) begin
      kind = (roll < 70) ? pbv_pkg::REQ_ERASE : REQ_UNUSED_LAST;
    end else begin
      kind = (roll < 85)
             ? req_code_t'($urandom_range(pbv_pkg::REQ_ERASE, pbv_pkg::REQ_APPEND))
             : REQ_UNUSED_LAST;
    end
    // in-range position for the chosen op, or noise
    case (kind)
      pbv_pkg::REQ_INSERT:
        pos = $urandom_range((fill_est > POS_MAX) ? POS_MAX : fill_est, 0);
      pbv_pkg::REQ_READ, pbv_pkg::REQ_WRITE, pbv_pkg::REQ_ERASE:
        pos = (fill_est > 0) ? $urandom_range(fill_est - 1, 0) : $urandom_range(POS_MAX, 0);
      pbv_pkg::REQ_APPEND: pos = $urandom_range(POS_MAX, 0);
      default: begin
        kind = req_code_t'($urandom_range(REQ_UNUSED_LAST, pbv_pkg::REQ_APPEND));
        pos  = $urandom_range(POS_MAX, 0);
      end
    endcase
    send_item(kind, pos, 1'($urandom_range(1, 0)));
  endtask

  // receiver: random ready with two long hold-offs to back the block up
  initial begin
    int next_hold_at, gap;
    next_hold_at = 100;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (next_hold_at > 0 && items_sent >= next_hold_at) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        next_hold_at = (next_hold_at == 100) ? 650 : 0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          rsp_ch.ready <= 1'b1;
          @(posedge clk);
        end else begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    int random_sent, phase_items, past_edge;
    phase_t phase;
    items_sent = 0;
    fill_est   = 0;
    calm       = 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= pbv_pkg::REQ_APPEND;
    req_ch.position  <= '0;
    req_ch.bit_value <= 1'b0;
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed: empty-vector rejects, then small edits ---
    send_item(pbv_pkg::REQ_READ, 0, 1'b0);       // read from empty
    send_item(pbv_pkg::REQ_ERASE, 0, 1'b0);      // erase from empty
    send_item(pbv_pkg::REQ_WRITE, 0, 1'b1);      // write to empty
    send_item(pbv_pkg::REQ_INSERT, 1, 1'b1);     // insert past the end
    send_item(pbv_pkg::REQ_INSERT, 0, 1'b1);     // insert into empty
    send_item(pbv_pkg::REQ_APPEND, 0, 1'b0);
    send_item(pbv_pkg::REQ_APPEND, POS_MAX, 1'b1);
    send_item(pbv_pkg::REQ_READ, 0, 1'b0);
    send_item(pbv_pkg::REQ_READ, 1, 1'b0);
    send_item(pbv_pkg::REQ_READ, 2, 1'b0);
    send_item(pbv_pkg::REQ_WRITE, 1, 1'b1);
    send_item(pbv_pkg::REQ_READ, 1, 1'b0);
    send_item(pbv_pkg::REQ_INSERT, 3, 1'b0);     // insert at position == length
    send_item(pbv_pkg::REQ_INSERT, 0, 1'b0);     // insert at front, shifts all
    send_item(pbv_pkg::REQ_READ, 4, 1'b0);
    send_item(pbv_pkg::REQ_ERASE, 0, 1'b0);      // erase front
    send_item(pbv_pkg::REQ_ERASE, 3, 1'b0);      // erase last
    send_item(pbv_pkg::REQ_READ, 3, 1'b0);       // just past the end now
    send_item(pbv_pkg::REQ_READ, POS_MAX, 1'b0);
    send_item(pbv_pkg::REQ_WRITE, POS_MAX, 1'b1);
    send_item(pbv_pkg::REQ_ERASE, POS_MAX, 1'b1);
    send_item(REQ_UNUSED_FIRST, POS_MAX, 1'b1);
    send_item(req_code_t'(REQ_UNUSED_FIRST + 1), 0, 1'b0);
    send_item(REQ_UNUSED_LAST, POS_MAX, 1'b1);

    // --- random phases: grow to full, mix, shrink to empty, mix ---
    random_sent = 0;
    phase = PH_GROW;
    while (random_sent < RANDOM_ITEMS) begin
      phase_items = 0;
      past_edge   = 0;
      while (random_sent < RANDOM_ITEMS && phase_items < PHASE_CAP) begin
        send_random_item(phase);
        random_sent++;
        phase_items++;
        // keep poking a few items once full or empty to hit the rejects there
        if (phase == PH_GROW && fill_est == CAP) past_edge++;
        if (phase == PH_SHRINK && fill_est == 0) past_edge++;
        if (past_edge >= 6) break;
        if (phase == PH_MIX && phase_items >= MIX_ITEMS) break;
      end
      case (phase)
        PH_GROW:   phase = PH_MIX;
        PH_MIX:    phase = (fill_est > CAP / 2) ? PH_SHRINK : PH_GROW;
        default:   phase = PH_MIX;
      endcase
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d out-of-range and %0d store-full rejects,",
             results_seen, range_rejects, full_rejects);
    $display("vector length peaked at %0d of %0d bits.", peak_length, CAP);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
